// ===== hdl/psu_pkg.sv =====
// Shared types, constants and the Paeth predictor for the PNG scanline unfilter.
// No dependencies; every other file in hdl refers to this package by scoped name.
package psu_pkg;

  localparam int MAX_ROW_BYTES_DEF = 16384;
  localparam int MAX_ROWS_DEF      = 4096;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [1:0]  REG_BPP        = 2'd0;
  localparam logic [1:0]  REG_ROW_LENGTH = 2'd1;
  localparam logic [1:0]  REG_ROW_TOTAL  = 2'd2;

  localparam logic [2:0]  BPP_RESET        = 3'd4;
  localparam logic [14:0] ROW_LENGTH_RESET = 15'd4;
  localparam logic [12:0] ROW_TOTAL_RESET  = 13'd1;

  localparam logic [7:0]  FILTER_MAX = 8'd4;
  localparam int          RGB_BYTES  = 3;
  localparam int          RGBA_BYTES = 4;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_t;

  typedef struct packed {
    logic    bad;
    filter_t filter;
    logic    wide;
    logic    first_row;
    logic    row_end;
    logic    image_end;
  } item_flags_t;

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [9:0] sa;
    logic signed [9:0] sb;
    logic signed [9:0] sc;
    logic signed [9:0] p;
    logic signed [9:0] ea;
    logic signed [9:0] eb;
    logic signed [9:0] ec;
    logic [9:0] da;
    logic [9:0] db;
    logic [9:0] dc;
    sa = $signed({2'b00, a});
    sb = $signed({2'b00, b});
    sc = $signed({2'b00, c});
    p  = sa + sb - sc;
    ea = p - sa;
    eb = p - sb;
    ec = p - sc;
    da = (ea < 0) ? 10'(-ea) : 10'(ea);
    db = (eb < 0) ? 10'(-eb) : 10'(eb);
    dc = (ec < 0) ? 10'(-ec) : 10'(ec);
    if (da <= db && da <= dc) begin
      paeth_pick = a;
    end else if (db <= dc) begin
      paeth_pick = b;
    end else begin
      paeth_pick = c;
    end
  endfunction

endpackage

// ===== hdl/psu_front.sv =====
// Front end: accepts stream bytes, tracks filter type, column and row, and queues
// each data byte as a sample item and each bad filter byte as an error item. Depends on psu_pkg.
module psu_front #(
  parameter int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_ROWS      = psu_pkg::MAX_ROWS_DEF,
  localparam int CW = $clog2(MAX_ROW_BYTES),
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  raw_valid,
  output logic                  raw_stall,
  input  logic [7:0]            raw_byte,
  input  logic [2:0]            bytes_per_pixel,
  input  logic [14:0]           row_length,
  input  logic [12:0]           row_total,
  input  logic                  queue_full,
  output logic                  push,
  output psu_pkg::item_flags_t  push_flags,
  output logic [7:0]            push_raw,
  output logic [CW-1:0]         push_col
);

  localparam int LW = ($clog2(MAX_ROW_BYTES + 1) > 15) ? $clog2(MAX_ROW_BYTES + 1) : 15;
  localparam int TW = ($clog2(MAX_ROWS + 1) > 13) ? $clog2(MAX_ROWS + 1) : 13;

  logic             awaiting;
  logic             awaiting_next;
  psu_pkg::filter_t filter;
  psu_pkg::filter_t filter_next;
  logic [CW-1:0]    col;
  logic [CW-1:0]    col_next;
  logic [RW-1:0]    row;
  logic [RW-1:0]    row_next;

  logic          accept;
  logic [LW-1:0] len_eff;
  logic [TW-1:0] rows_eff;
  logic          last_col;
  logic          last_row;

  assign raw_stall = queue_full;
  assign accept    = raw_valid && !queue_full;

  always_comb begin
    if (row_length == 15'd0) begin
      len_eff = LW'(1);
    end else if (LW'(row_length) > LW'(MAX_ROW_BYTES)) begin
      len_eff = LW'(MAX_ROW_BYTES);
    end else begin
      len_eff = LW'(row_length);
    end
    if (row_total == 13'd0) begin
      rows_eff = TW'(1);
    end else if (TW'(row_total) > TW'(MAX_ROWS)) begin
      rows_eff = TW'(MAX_ROWS);
    end else begin
      rows_eff = TW'(row_total);
    end
  end

  assign last_col = (LW'(col) + LW'(1)) >= len_eff;
  assign last_row = (TW'(row) + TW'(1)) >= rows_eff;

  always_comb begin
    awaiting_next = awaiting;
    filter_next   = filter;
    col_next      = col;
    row_next      = row;
    push          = 1'b0;
    push_flags    = '0;
    push_raw      = raw_byte;
    push_col      = col;
    if (accept) begin
      if (awaiting) begin
        if (raw_byte > psu_pkg::FILTER_MAX) begin
          push                 = 1'b1;
          push_flags.bad       = 1'b1;
          push_flags.image_end = 1'b1;
          awaiting_next        = 1'b1;
          filter_next          = psu_pkg::FILT_NONE;
          col_next             = '0;
          row_next             = '0;
        end else begin
          filter_next   = psu_pkg::filter_t'(raw_byte[2:0]);
          awaiting_next = 1'b0;
          col_next      = '0;
        end
      end else begin
        push                 = 1'b1;
        push_flags.filter    = filter;
        push_flags.wide      = (bytes_per_pixel >= 3'(psu_pkg::RGBA_BYTES));
        push_flags.first_row = (row == '0);
        push_flags.row_end   = last_col;
        push_flags.image_end = last_col && last_row;
        if (last_col) begin
          col_next      = '0;
          awaiting_next = 1'b1;
          if (last_row) begin
            row_next    = '0;
            filter_next = psu_pkg::FILT_NONE;
          end else begin
            row_next = row + RW'(1);
          end
        end else begin
          col_next = col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting <= 1'b1;
      filter   <= psu_pkg::FILT_NONE;
      col      <= '0;
      row      <= '0;
    end else begin
      awaiting <= awaiting_next;
      filter   <= filter_next;
      col      <= col_next;
      row      <= row_next;
    end
  end

endmodule

// ===== hdl/psu_queue.sv =====
// Short queue between the front end and the reconstruction back end.
// Register array with head and tail pointers; depth from psu_pkg.
module psu_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              nonempty,
  output logic [DATA_W-1:0] head_data
);

  localparam int PW = $clog2(psu_pkg::QUEUE_DEPTH);
  localparam int NW = $clog2(psu_pkg::QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slots [psu_pkg::QUEUE_DEPTH];
  logic [PW-1:0]     head;
  logic [PW-1:0]     tail;
  logic [NW-1:0]     count;

  assign full      = (count == NW'(psu_pkg::QUEUE_DEPTH));
  assign nonempty  = (count != '0);
  assign head_data = slots[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + PW'(1);
      end
      if (pop) begin
        head <= head + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_data;
    end
  end

endmodule

// ===== hdl/psu_back.sv =====
// Back end: reads the line store, applies the row filter, writes the row back
// and holds the result register. Depends on psu_pkg (flags, filter codes, Paeth).
module psu_back #(
  parameter int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF,
  localparam int CW = $clog2(MAX_ROW_BYTES)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  psu_pkg::item_flags_t q_flags,
  input  logic [7:0]           q_raw,
  input  logic [CW-1:0]        q_col,
  output logic                 pop,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [7:0]           sample_byte,
  output logic                 row_end,
  output logic                 image_end,
  output logic                 bad_filter
);

  logic [7:0] line_store [MAX_ROW_BYTES];
  logic [7:0] store_q;

  logic                 s1_valid;
  logic                 s1_valid_next;
  psu_pkg::item_flags_t s1_flags;
  logic [7:0]           s1_raw;
  logic [CW-1:0]        s1_col;
  logic                 s1_fwd;
  logic                 s1_adv;

  logic [7:0] lhist [4];
  logic [7:0] uhist [4];

  logic       res_valid_next;
  logic [1:0] hist_sel;
  logic       col_ge;
  logic [7:0] above;
  logic [7:0] left;
  logic [7:0] upleft;
  logic [8:0] avg_sum;
  logic [7:0] pred;
  logic [7:0] sample;
  logic       wr;

  assign s1_adv = s1_valid && (!res_valid || !res_stall);
  assign pop    = q_valid && (!s1_valid || s1_adv);
  assign wr     = s1_adv && !s1_flags.bad;

  always_comb begin
    s1_valid_next = s1_valid;
    if (pop) begin
      s1_valid_next = 1'b1;
    end else if (s1_adv) begin
      s1_valid_next = 1'b0;
    end
    res_valid_next = res_valid;
    if (s1_adv) begin
      res_valid_next = 1'b1;
    end else if (!res_stall) begin
      res_valid_next = 1'b0;
    end
  end

  always_comb begin
    hist_sel = {1'b1, s1_flags.wide};
    col_ge   = s1_flags.wide ? (s1_col >= CW'(psu_pkg::RGBA_BYTES))
                             : (s1_col >= CW'(psu_pkg::RGB_BYTES));
    above    = s1_flags.first_row ? 8'd0 : (s1_fwd ? lhist[0] : store_q);
    left     = col_ge ? lhist[hist_sel] : 8'd0;
    upleft   = col_ge ? uhist[hist_sel] : 8'd0;
    avg_sum  = {1'b0, left} + {1'b0, above};
    case (s1_flags.filter)
      psu_pkg::FILT_NONE:  pred = 8'd0;
      psu_pkg::FILT_SUB:   pred = left;
      psu_pkg::FILT_UP:    pred = above;
      psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
      psu_pkg::FILT_PAETH: pred = psu_pkg::paeth_pick(left, above, upleft);
      default:             pred = 8'd0;
    endcase
    sample = s1_raw + pred;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      res_valid <= res_valid_next;
    end
  end

  // forward the sample being written when the next read hits the same column
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_flags <= q_flags;
      s1_raw   <= q_raw;
      s1_col   <= q_col;
      s1_fwd   <= wr && (s1_col == q_col);
      store_q  <= line_store[q_col];
    end
    if (wr) begin
      line_store[s1_col] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      lhist[0] <= sample;
      uhist[0] <= above;
      for (int k = 1; k < 4; k++) begin
        lhist[k] <= lhist[k-1];
        uhist[k] <= uhist[k-1];
      end
    end
    if (s1_adv) begin
      sample_byte <= s1_flags.bad ? 8'd0 : sample;
      row_end     <= s1_flags.row_end && !s1_flags.bad;
      image_end   <= s1_flags.image_end;
      bad_filter  <= s1_flags.bad;
    end
  end

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_col) && $stable(s1_raw))
    else $error("stage item changed while held");

  a_end_order: assert property (@(posedge clk) disable iff (rst)
    res_valid && !bad_filter |-> !image_end || row_end)
    else $error("image end without row end");

  a_bad_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && bad_filter |-> sample_byte == 8'd0 && !row_end && image_end)
    else $error("malformed error result");

endmodule

// ===== hdl/png_scanline_unfilter.sv =====
// PNG scanline unfilter: one byte per cycle sustained while neither the queue nor the
// result port stalls, throughput set by the single read and write port pair of the
// line store and the history feedback. A sample passes through the queue, the stage-one
// registers and the result register; the queue holds four items between front and back.
// Reset clears the counters, the filter state and the registers to their reset
// values; the line store is not cleared and needs no pass after reset.
module png_scanline_unfilter #(
  parameter int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_ROWS      = psu_pkg::MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        raw_valid,
  output logic        raw_stall,
  input  logic [7:0]  raw_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  sample_byte,
  output logic        row_end,
  output logic        image_end,
  output logic        bad_filter
);

  localparam int CW = $clog2(MAX_ROW_BYTES);
  localparam int FW = $bits(psu_pkg::item_flags_t);
  localparam int DW = CW + 8 + FW;

  logic [2:0]  bytes_per_pixel;
  logic [14:0] row_length;
  logic [12:0] row_total;

  logic                 queue_full;
  logic                 push;
  psu_pkg::item_flags_t push_flags;
  logic [7:0]           push_raw;
  logic [CW-1:0]        push_col;
  logic                 pop;
  logic                 q_valid;
  logic [DW-1:0]        q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= psu_pkg::BPP_RESET;
      row_length      <= psu_pkg::ROW_LENGTH_RESET;
      row_total       <= psu_pkg::ROW_TOTAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psu_pkg::REG_BPP:        bytes_per_pixel <= cfg_data[2:0];
        psu_pkg::REG_ROW_LENGTH: row_length      <= cfg_data;
        psu_pkg::REG_ROW_TOTAL:  row_total       <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  psu_front #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES),
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .raw_valid(raw_valid),
    .raw_stall(raw_stall),
    .raw_byte(raw_byte),
    .bytes_per_pixel(bytes_per_pixel),
    .row_length(row_length),
    .row_total(row_total),
    .queue_full(queue_full),
    .push(push),
    .push_flags(push_flags),
    .push_raw(push_raw),
    .push_col(push_col)
  );

  psu_queue #(
    .DATA_W(DW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data({push_col, push_raw, push_flags}),
    .full(queue_full),
    .pop(pop),
    .nonempty(q_valid),
    .head_data(q_data)
  );

  psu_back #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_flags(psu_pkg::item_flags_t'(q_data[FW-1:0])),
    .q_raw(q_data[FW+7:FW]),
    .q_col(q_data[DW-1:FW+8]),
    .pop(pop),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .sample_byte(sample_byte),
    .row_end(row_end),
    .image_end(image_end),
    .bad_filter(bad_filter)
  );

endmodule

// ===== dv/tb_png_scanline_unfilter.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for png_scanline_unfilter: byte stream in, reconstructed
// samples out, checked against an in-bench unfilter predictor with its own line store.
// Depends on hdl/psu_pkg.sv and hdl/png_scanline_unfilter.sv.
module tb_png_scanline_unfilter;

  localparam logic [1:0] REG_UNUSED   = 2'd3;
  localparam int         QUIET_LIMIT  = 2000;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         LONG_HOLD    = 200;
  localparam int         RANDOM_ITEMS = 520;
  localparam int         HOLD_ROW_LEN = 40;

  typedef struct packed {
    logic [7:0] sample;
    logic       row_end;
    logic       image_end;
    logic       bad;
  } recon_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;
  logic        raw_valid = 1'b0;
  logic        raw_stall;
  logic [7:0]  raw_byte = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [7:0]  sample_byte;
  logic        row_end;
  logic        image_end;
  logic        bad_filter;

  png_scanline_unfilter dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .raw_valid   (raw_valid),
    .raw_stall   (raw_stall),
    .raw_byte    (raw_byte),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .sample_byte (sample_byte),
    .row_end     (row_end),
    .image_end   (image_end),
    .bad_filter  (bad_filter)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  logic [7:0] stream_q[$];
  recon_t     recon_expect[$];
  int         error_count = 0;
  int         queued_total = 0;
  int         hold_request = 0;
  int         hold_seen = 0;
  int         src_gap = 0;
  int         stall_left = 0;
  int         quiet_cycles = 0;
  logic       calm = 1'b0;
  int         plan_len;
  int         plan_rows;

  // predictor state and register copies
  logic [7:0]        prior_row [psu_pkg::MAX_ROW_BYTES_DEF];
  logic [7:0]        left_hist [4];
  logic [7:0]        upleft_hist [4];
  int                col_pos;
  int                row_pos;
  psu_pkg::filter_t  cur_filter;
  logic              awaiting_filter;
  logic [2:0]        bpp_reg;
  logic [14:0]       len_reg;
  logic [12:0]       rows_reg;

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    error_count++;
  endtask

  task automatic clear_history();
    for (int k = 0; k < 4; k++) begin
      left_hist[k] = 8'h00;
      upleft_hist[k] = 8'h00;
    end
  endtask

  task automatic rewind_image();
    clear_history();
    col_pos = 0;
    row_pos = 0;
    cur_filter = psu_pkg::FILT_NONE;
    awaiting_filter = 1'b1;
  endtask

  task automatic unfilter_step(input logic [7:0] raw);
    int bpp, len, rows, a_i, b_i, c_i, pv, da, db, dc;
    logic [7:0] above, left, upleft, pred, sample;
    logic [8:0] sum9;
    logic last_col, last_row;
    if (awaiting_filter) begin
      if (raw > psu_pkg::FILTER_MAX) begin
        recon_expect.push_back('{sample: 8'h00, row_end: 1'b0, image_end: 1'b1, bad: 1'b1});
        rewind_image();
      end else begin
        cur_filter = psu_pkg::filter_t'(raw[2:0]);
        awaiting_filter = 1'b0;
        col_pos = 0;
        clear_history();
      end
      return;
    end
    bpp = (bpp_reg < psu_pkg::RGB_BYTES) ? psu_pkg::RGB_BYTES :
          ((bpp_reg > psu_pkg::RGBA_BYTES) ? psu_pkg::RGBA_BYTES : bpp_reg);
    len = (len_reg == 0) ? 1 : ((len_reg > psu_pkg::MAX_ROW_BYTES_DEF) ?
                                psu_pkg::MAX_ROW_BYTES_DEF : len_reg);
    rows = (rows_reg == 0) ? 1 : ((rows_reg > psu_pkg::MAX_ROWS_DEF) ?
                                  psu_pkg::MAX_ROWS_DEF : rows_reg);
    above = (row_pos == 0) ? 8'h00 : prior_row[col_pos];
    left = left_hist[bpp - 1];
    upleft = upleft_hist[bpp - 1];
    case (cur_filter)
      psu_pkg::FILT_SUB: pred = left;
      psu_pkg::FILT_UP: pred = above;
      psu_pkg::FILT_AVG: begin
        sum9 = {1'b0, left} + {1'b0, above};
        pred = sum9[8:1];
      end
      psu_pkg::FILT_PAETH: begin
        a_i = left;
        b_i = above;
        c_i = upleft;
        pv = a_i + b_i - c_i;
        da = (pv > a_i) ? pv - a_i : a_i - pv;
        db = (pv > b_i) ? pv - b_i : b_i - pv;
        dc = (pv > c_i) ? pv - c_i : c_i - pv;
        if (da <= db && da <= dc) pred = left;
        else if (db <= dc) pred = above;
        else pred = upleft;
      end
      default: pred = 8'h00;
    endcase
    sample = raw + pred;
    for (int k = 3; k > 0; k--) begin
      left_hist[k] = left_hist[k - 1];
      upleft_hist[k] = upleft_hist[k - 1];
    end
    left_hist[0] = sample;
    upleft_hist[0] = above;
    prior_row[col_pos] = sample;
    last_col = (col_pos + 1 >= len);
    last_row = (row_pos + 1 >= rows);
    recon_expect.push_back('{sample: sample, row_end: last_col,
                             image_end: last_col && last_row, bad: 1'b0});
    if (last_col) begin
      if (last_row) begin
        rewind_image();
      end else begin
        row_pos++;
        col_pos = 0;
        awaiting_filter = 1'b1;
        clear_history();
      end
    end else begin
      col_pos++;
    end
  endtask

  // byte driver and predictor update
  always @(posedge clk) begin
    if (rst) begin
      raw_valid <= 1'b0;
      src_gap <= 0;
      bpp_reg = psu_pkg::BPP_RESET;
      len_reg = psu_pkg::ROW_LENGTH_RESET;
      rows_reg = psu_pkg::ROW_TOTAL_RESET;
      rewind_image();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          psu_pkg::REG_BPP: bpp_reg = cfg_data[2:0];
          psu_pkg::REG_ROW_LENGTH: len_reg = cfg_data;
          psu_pkg::REG_ROW_TOTAL: rows_reg = cfg_data[12:0];
          default: ;
        endcase
      end
      if (raw_valid && !raw_stall) unfilter_step(raw_byte);
      if (raw_valid && raw_stall) begin
        // hold the stalled transfer
      end else if (src_gap != 0) begin
        src_gap <= src_gap - 1;
        raw_valid <= 1'b0;
      end else if (stream_q.size() != 0 && (calm || $urandom_range(0, 11) != 0)) begin
        raw_valid <= 1'b1;
        raw_byte <= stream_q.pop_front();
      end else begin
        raw_valid <= 1'b0;
        if (stream_q.size() != 0) src_gap <= $urandom_range(0, 15);
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    recon_t want;
    if (rst) begin
      res_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (recon_expect.size() == 0) begin
          flag_mismatch($sformatf("unexpected result sample_byte=%02h", sample_byte));
        end else begin
          want = recon_expect.pop_front();
          if (sample_byte !== want.sample)
            flag_mismatch($sformatf("sample_byte %02h, want %02h", sample_byte, want.sample));
          if (row_end !== want.row_end)
            flag_mismatch($sformatf("row_end %b, want %b", row_end, want.row_end));
          if (image_end !== want.image_end)
            flag_mismatch($sformatf("image_end %b, want %b", image_end, want.image_end));
          if (bad_filter !== want.bad)
            flag_mismatch($sformatf("bad_filter %b, want %b", bad_filter, want.bad));
        end
      end
      if (hold_seen != hold_request) begin
        hold_seen <= hold_request;
        stall_left <= LONG_HOLD - 1;
        res_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        res_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_left <= $urandom_range(0, 15);
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((raw_valid && !raw_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_png_scanline_unfilter: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic offer(input logic [7:0] b);
    stream_q.push_back(b);
    queued_total++;
  endtask

  task automatic push_row(input logic [7:0] filt, input int n);
    offer(filt);
    repeat (n) begin
      case ($urandom_range(0, 7))
        0: offer(8'h00);
        1: offer(8'hFF);
        default: offer(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic settle();
    do @(posedge clk); while (stream_q.size() != 0 || raw_valid || recon_expect.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_shape(input logic [2:0] bpp, input logic [14:0] len,
                           input logic [12:0] rows);
    write_reg(psu_pkg::REG_BPP, 15'(bpp));
    write_reg(psu_pkg::REG_ROW_LENGTH, len);
    write_reg(psu_pkg::REG_ROW_TOTAL, 15'(rows));
    plan_len = (len == 0) ? 1 : ((len > psu_pkg::MAX_ROW_BYTES_DEF) ?
                                 psu_pkg::MAX_ROW_BYTES_DEF : len);
    plan_rows = (rows == 0) ? 1 : ((rows > psu_pkg::MAX_ROWS_DEF) ?
                                   psu_pkg::MAX_ROWS_DEF : rows);
  endtask

  initial begin
    logic [7:0] edge_bytes [4] = '{8'hFF, 8'h80, 8'h00, 8'hFF};
    psu_pkg::filter_t dir_filters [3] = '{psu_pkg::FILT_SUB, psu_pkg::FILT_PAETH,
                                          psu_pkg::FILT_AVG};
    logic [2:0] r_bpp;
    logic [14:0] r_len;
    logic [12:0] r_rows;
    int random_start, phase_no, rows_to_send;
    logic aborted;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_UNUSED, 15'h7FFF);
    set_shape(3'd3, 15'd4, 13'd3);
    foreach (dir_filters[r]) begin
      offer(8'(dir_filters[r]));
      foreach (edge_bytes[j]) offer(edge_bytes[j]);
    end
    offer(psu_pkg::FILTER_MAX + 8'd1);
    settle();

    // change registers partway through a row and between rows
    set_shape(3'd3, 15'd8, 13'd3);
    push_row(8'(psu_pkg::FILT_NONE), 5);
    settle();
    write_reg(psu_pkg::REG_ROW_LENGTH, 15'd4);
    write_reg(psu_pkg::REG_BPP, 15'd4);
    offer(8'($urandom_range(0, 255)));
    settle();
    write_reg(psu_pkg::REG_ROW_TOTAL, 15'd2);
    push_row(8'(psu_pkg::FILT_UP), 4);

    random_start = queued_total;
    phase_no = 0;
    while (queued_total - random_start < RANDOM_ITEMS) begin
      settle();
      r_bpp = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                          : 3'($urandom_range(psu_pkg::RGB_BYTES,
                                                              psu_pkg::RGBA_BYTES));
      case ($urandom_range(0, 9))
        0: r_len = 15'd0;
        1: r_len = 15'd3;
        2: r_len = 15'($urandom_range(1, 2));
        default: r_len = 15'($urandom_range(3, 24));
      endcase
      case ($urandom_range(0, 9))
        0: r_rows = 13'd0;
        1: r_rows = 13'($urandom_range(psu_pkg::MAX_ROWS_DEF + 1, 8191));
        2: r_rows = 13'(psu_pkg::MAX_ROWS_DEF);
        default: r_rows = 13'($urandom_range(1, 5));
      endcase
      set_shape(r_bpp, r_len, r_rows);
      repeat ($urandom_range(1, 3)) begin
        rows_to_send = (plan_rows > 5) ? $urandom_range(1, 4) : plan_rows;
        aborted = 1'b0;
        for (int r = 0; r < rows_to_send && !aborted; r++) begin
          if ($urandom_range(0, 19) == 0) begin
            offer(8'($urandom_range(int'(psu_pkg::FILTER_MAX) + 1, 255)));
            aborted = 1'b1;
          end else begin
            push_row(8'($urandom_range(psu_pkg::FILT_NONE, psu_pkg::FILT_PAETH)), plan_len);
          end
        end
        if (!aborted && rows_to_send < plan_rows)
          offer(8'($urandom_range(int'(psu_pkg::FILTER_MAX) + 1, 255)));
      end
      if (phase_no == 4) hold_request <= hold_request + 1;
      phase_no++;
    end

    // long rows, with the receiver holding off early on
    settle();
    set_shape(3'd4, 15'(HOLD_ROW_LEN), 13'd2);
    push_row(8'($urandom_range(psu_pkg::FILT_NONE, psu_pkg::FILT_PAETH)), plan_len);
    push_row(8'($urandom_range(psu_pkg::FILT_NONE, psu_pkg::FILT_PAETH)), plan_len);
    hold_request <= hold_request + 1;

    settle();
    calm <= 1'b1;
    set_shape(3'd4, 15'd8, 13'd3);
    repeat (2) begin
      for (int r = 0; r < plan_rows; r++)
        push_row(8'($urandom_range(psu_pkg::FILT_NONE, psu_pkg::FILT_PAETH)), plan_len);
    end
    settle();

    if (error_count == 0) $display("tb_png_scanline_unfilter: PASS");
    else $display("tb_png_scanline_unfilter: FAIL");
    $finish;
  end

endmodule
